// ===== sv/mhic_pkg.sv =====
// shared types and constants for the magnetometer hard-iron centering block
package mhic_pkg;

    // axis geometry and field widths
    localparam int AXES_MAX       = 3;
    localparam int AXIS_COUNT_DEF = 3;
    localparam int AXIS_W         = 16;
    localparam int GAIN_W         = 16;
    localparam int PROD_W         = AXIS_W + GAIN_W;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    // register reset values (q0.16 gains, about 0.161 and 0.294)
    localparam logic [GAIN_W-1:0] XY_GAIN_RST = 16'd10551;
    localparam logic [GAIN_W-1:0] Z_GAIN_RST  = 16'd19268;

    // register selector, taken from address bit 2
    localparam logic REG_XY_GAIN = 1'b0;
    localparam logic REG_Z_GAIN  = 1'b1;

    // lane index that takes the z gain
    localparam int Z_LANE = 2;

    // per-lane pipeline control from the top level
    typedef struct packed {
        logic load;   // request accepted, capture scaled sample
        logic adv;    // scaled sample moves into the output register
        logic seed;   // seed mode for the sample that advances
    } t_lane_ctrl;

endpackage

// ===== sv/mhic_cfg.sv =====
// apb register file holding the xy and z gains
module mhic_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mhic_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mhic_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mhic_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [mhic_pkg::GAIN_W-1:0]        o_xy_gain,
    output logic [mhic_pkg::GAIN_W-1:0]        o_z_gain
);
    import mhic_pkg::*;

    logic [GAIN_W-1:0] r_xy;
    logic [GAIN_W-1:0] r_z;
    logic              w_wr;
    logic              w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_sel  = paddr[2];

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xy <= XY_GAIN_RST;
            r_z  <= Z_GAIN_RST;
        end else if (w_wr) begin
            if (w_sel == REG_XY_GAIN) begin
                r_xy <= pwdata[GAIN_W-1:0];
            end
            if (w_sel == REG_Z_GAIN) begin
                r_z <= pwdata[GAIN_W-1:0];
            end
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_sel)
            REG_XY_GAIN: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_xy};
            REG_Z_GAIN:  prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_z};
            default:     prdata = '0;
        endcase
    end

    assign o_xy_gain = r_xy;
    assign o_z_gain  = r_z;

endmodule

// ===== sv/mhic_lane.sv =====
// one axis lane: gain scaling, running min/max and centring
module mhic_lane (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  mhic_pkg::t_lane_ctrl                    i_ctrl,
    input  logic signed [mhic_pkg::AXIS_W-1:0]      i_raw,
    input  logic        [mhic_pkg::GAIN_W-1:0]      i_gain,
    output logic signed [mhic_pkg::AXIS_W-1:0]      o_out
);
    import mhic_pkg::*;

    logic        [AXIS_W-1:0] w_mag;
    logic        [PROD_W-1:0] w_prod;
    logic        [AXIS_W-1:0] w_quo;
    logic signed [AXIS_W-1:0] w_scl;
    logic signed [AXIS_W-1:0] r_scl;
    logic signed [AXIS_W-1:0] r_min;
    logic signed [AXIS_W-1:0] r_max;
    logic signed [AXIS_W-1:0] n_min;
    logic signed [AXIS_W-1:0] n_max;
    logic signed [AXIS_W:0]   w_sum;
    logic signed [AXIS_W:0]   w_half;
    logic signed [AXIS_W-1:0] w_diff;
    logic signed [AXIS_W-1:0] r_out;

    // sign-magnitude scaling, truncation toward zero
    assign w_mag  = i_raw[AXIS_W-1] ? AXIS_W'(-i_raw) : AXIS_W'(i_raw);
    assign w_prod = PROD_W'(w_mag) * PROD_W'(i_gain);
    assign w_quo  = w_prod[PROD_W-1:GAIN_W];
    assign w_scl  = i_raw[AXIS_W-1] ? signed'(AXIS_W'(-w_quo)) : signed'(w_quo);

    // scaled sample register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_scl <= w_scl;
        end
    end

    // widen or seed the running extremes
    always_comb begin
        if (i_ctrl.seed) begin
            n_min = r_scl;
            n_max = r_scl;
        end else begin
            n_min = (r_scl < r_min) ? r_scl : r_min;
            n_max = (r_scl > r_max) ? r_scl : r_max;
        end
    end

    // midpoint with division rounding toward zero, then wrap to 16 bits
    assign w_sum  = (AXIS_W+1)'(n_max) + (AXIS_W+1)'(n_min);
    assign w_half = (w_sum + {{AXIS_W{1'b0}}, w_sum[AXIS_W]}) >>> 1;
    assign w_diff = i_ctrl.seed ? r_scl : AXIS_W'(r_scl - w_half[AXIS_W-1:0]);

    // running min/max state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_ctrl.adv) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    // lane result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_out <= w_diff;
        end
    end

    assign o_out = r_out;

    // extremes stay ordered
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max) else $error("lane minimum above maximum");

    // seeding collapses the range onto the sample
    a_seed_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.adv && i_ctrl.seed) |=> (r_min == r_max) && (r_min == $past(r_scl)))
        else $error("seed did not set min and max to the sample");

    // an update leaves the sample inside the range
    a_update_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.adv && !i_ctrl.seed) |=>
            (r_min <= $past(r_scl)) && (r_max >= $past(r_scl)))
        else $error("update left the sample outside min/max");

endmodule

// ===== sv/magnetometer_hard_iron_centering_top.sv =====
// top level: stream channels, lanes per axis and the merged output word
// Magnetometer hard-iron centring, one three-axis sample per request.
// Input stream: s_axis_tdata carries raw_x, raw_y, raw_z (signed 16 bits,
// x lowest), s_axis_tuser carries mode (0 update and centre, 1 seed).
// Output stream: m_axis_tdata carries out_x, out_y, out_z, x lowest.
// Each axis has its own lane: a 16x16 gain multiply into a register, then
// the min/max update, the midpoint and the subtraction into the lane's output
// register. The lanes are merged into one output word.
// An accepted sample goes into each lane's scaled sample register, then its
// output register; throughput is one sample per cycle while m_axis_tready is
// high, each lane finishing its min/max update before the next sample comes.
// A new request is accepted while a finished result waits, as long as the
// scaling stage is free or moving on; when m_axis_tready stays low the two
// stages fill and s_axis_tready drops, holding all data in place.
// Gains are written through the apb port (xy_gain at 0x0, z_gain at 0x4);
// the user writes them only while no sample is in flight (block does not enforce it).
// Synchronous reset clears both valid flags, restores default gains and
// sets every axis minimum and maximum to zero. Axes at or beyond AXIS_COUNT
// keep no state and output zero.
module magnetometer_hard_iron_centering_top #(
    parameter int AXIS_COUNT = mhic_pkg::AXIS_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // raw_x [15:0], raw_y [31:16], raw_z [47:32]
    input  logic [3*mhic_pkg::AXIS_W-1:0]       s_axis_tdata,
    // mode [0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_x [15:0], out_y [31:16], out_z [47:32]
    output logic [3*mhic_pkg::AXIS_W-1:0]       m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mhic_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mhic_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mhic_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mhic_pkg::*;

    logic              r_s1_valid;
    logic              r_s1_mode;
    logic              r_out_valid;
    logic              w_out_ready;
    logic              w_s1_adv;
    logic              w_in_acc;
    logic [GAIN_W-1:0] w_xy_gain;
    logic [GAIN_W-1:0] w_z_gain;
    t_lane_ctrl        w_ctrl;
    logic signed [AXIS_W-1:0] w_lane_out [AXES_MAX];

    // configuration registers
    mhic_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_xy_gain (w_xy_gain),
        .o_z_gain  (w_z_gain)
    );

    // pipeline handshake
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_s1_adv      = r_s1_valid && w_out_ready;
    assign s_axis_tready = !r_s1_valid || w_out_ready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // mode follows the sample through the scaling stage
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_mode <= s_axis_tuser[0];
        end
    end

    assign w_ctrl.load = w_in_acc;
    assign w_ctrl.adv  = w_s1_adv;
    assign w_ctrl.seed = r_s1_mode;

    // one lane per processed axis, zero for the rest
    for (genvar g = 0; g < AXES_MAX; g++) begin : g_lane
        if (g < AXIS_COUNT) begin : g_on
            mhic_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_raw   (signed'(s_axis_tdata[g*AXIS_W +: AXIS_W])),
                .i_gain  ((g == Z_LANE) ? w_z_gain : w_xy_gain),
                .o_out   (w_lane_out[g])
            );
        end else begin : g_off
            assign w_lane_out[g] = '0;
        end
    end

    // merge lane results into the output word
    assign m_axis_tdata  = {w_lane_out[2], w_lane_out[1], w_lane_out[0]};
    assign m_axis_tvalid = r_out_valid;

    // an accepted request always lands in the scaling stage
    a_acc_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid) else $error("accepted request lost");

    // a sample leaving the scaling stage always becomes a result
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid) else $error("advancing sample dropped");

    // both stages full and stalled means no new request
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted into a full pipeline");

endmodule
